// ===== rtl/dspsg_pkg.sv =====
// ----------------------------------------------------------------------------
// dspsg_pkg: shared definitions for the dual servo PWM speed governor
// Event codes, select codes, register indexes, reset values, reload
// arithmetic constants, and the request and response bundles of the shared
// divider.
// ----------------------------------------------------------------------------
package dspsg_pkg;

  // Shared divider sizing: the slew difference is at most 255, the divisor
  // at most 48
  localparam int DIVIDEND_W = 8;
  localparam int DIVISOR_W  = 7;
  localparam int STEP_W     = $clog2(DIVIDEND_W);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Event codes
  localparam logic [1:0] OP_STEER    = 2'd0;
  localparam logic [1:0] OP_BRAKE    = 2'd1;
  localparam logic [1:0] OP_EDGE     = 2'd2;
  localparam logic [1:0] OP_DEBOUNCE = 2'd3;

  // Servo select codes
  localparam logic [1:0] SEL_STEER = 2'd0;
  localparam logic [1:0] SEL_BRAKE = 2'd1;
  localparam logic [1:0] SEL_NONE  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_ON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_OFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RISE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING    = 3'd7;

  // Reload arithmetic: the numerator is at most 255*1023+99. Division by 100
  // is a multiply by ceil(2^25/100) keeping bits 25 and up, exact over that
  // whole range.
  localparam int RELOAD_W    = 18;
  localparam int RECIP_W     = 19;
  localparam int RECIP_SHIFT = 25;
  localparam int RELOAD_Q_W  = 12;
  localparam int PROD_W      = RELOAD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RELOAD_RECIP = 19'd335545;
  localparam logic [15:0] HIGH_BASE = 16'd65075;
  localparam logic [15:0] LOW_BASE  = 16'd47566;
  localparam logic [RELOAD_W-1:0] ROUND_UP   = 18'd99;
  localparam logic [6:0]          RELOAD_DIV = 7'd100;
  localparam logic [7:0] SLEW_BIAS  = 8'd2;
  localparam logic [5:0] SPEED_SPAN = 6'd32;

  // Reset values
  localparam logic [7:0] RST_BRAKE_ON   = 8'd93;
  localparam logic [7:0] RST_BRAKE_OFF  = 8'd70;
  localparam logic [5:0] RST_SPEED_HIGH = 6'd15;
  localparam logic [5:0] RST_SPEED_LOW  = 6'd8;
  localparam logic [7:0] RST_MAX_RISE   = 8'd50;
  localparam logic [5:0] RST_WINDOW     = 6'd25;
  localparam logic [4:0] RST_FLOOR      = 5'd6;
  localparam logic [4:0] RST_CEILING    = 5'd25;
  localparam logic [7:0] RST_ANGLE      = 8'd90;
  localparam logic [4:0] RST_SPEED      = 5'd6;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/dspsg_divider.sv =====
// ----------------------------------------------------------------------------
// dspsg_divider: shared restoring divider
// One quotient bit per cycle; done pulses with the quotient once all
// DIVIDEND_W quotient bits are formed.
// ----------------------------------------------------------------------------
module dspsg_divider (
  input  logic               clk,
  input  logic               rst,
  input  dspsg_pkg::div_req_t req,
  output dspsg_pkg::div_rsp_t rsp
);

  localparam logic [dspsg_pkg::STEP_W-1:0] LAST_STEP =
    dspsg_pkg::STEP_W'(dspsg_pkg::DIVIDEND_W - 1);

  logic                               busy;
  logic                               done;
  logic [dspsg_pkg::STEP_W-1:0]       cnt;
  logic [dspsg_pkg::DIVISOR_W-1:0]    rem;
  logic [dspsg_pkg::DIVISOR_W-1:0]    dsr;
  logic [dspsg_pkg::DIVIDEND_W-1:0]   quo;
  logic [dspsg_pkg::DIVISOR_W:0]      trial;
  logic [dspsg_pkg::DIVISOR_W:0]      trial_sub;
  logic                               fits;

  // Shift in the next dividend bit and try the subtract
  assign trial     = {rem, quo[dspsg_pkg::DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dsr};
  assign fits      = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? trial_sub[dspsg_pkg::DIVISOR_W-1:0] : trial[dspsg_pkg::DIVISOR_W-1:0];
      quo <= {quo[dspsg_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/dual_servo_pwm_speed_governor.sv =====
// ----------------------------------------------------------------------------
// dual_servo_pwm_speed_governor: two-servo PWM phase driver with speed governor
// Turns timer-overflow, encoder-edge and debounce-expiry events into servo
// pin levels, timer reloads, and encoder speed and distance figures.
// ----------------------------------------------------------------------------
// One event is taken at a time; in_stall stays high until its result sits in
// the output register, which then waits for the downstream side while the next
// event may already come in. Encoder-edge and debounce-expiry events go from
// the transfer cycle straight to ST_FINISH. For a servo event the transfer
// cycle forms angle*1023 (plus 99 when rounding up), the next divides by 100
// through a reciprocal multiply and forms the reload. A steering low phase
// whose angle must move adds a pass through the shared 8-step restoring
// divider for the slew step; a brake low phase that closes a speed window adds
// the window update states ST_WIN_RISE, ST_WIN_CAP and ST_WIN_APPLY. A blocked
// output register holds the result in ST_FINISH until it is free again.
// Configuration writes land at any cycle and must only come while the block
// is idle.
// ----------------------------------------------------------------------------
module dual_servo_pwm_speed_governor (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_write,
  input  logic [dspsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dspsg_pkg::CFG_DATA_W-1:0] cfg_data,
  // event channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       operation,
  input  logic [7:0]                       target_angle,
  input  logic                             need_brake,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       servo_select,
  output logic                             pin_level,
  output logic [15:0]                      reload_value,
  output logic                             debounce_start,
  output logic                             pulse_enable,
  output logic [4:0]                       measured_speed,
  output logic [15:0]                      distance_total
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_RELOAD    = 3'd1;
  localparam logic [2:0] ST_DIV_SLEW  = 3'd2;
  localparam logic [2:0] ST_WIN_RISE  = 3'd3;
  localparam logic [2:0] ST_WIN_CAP   = 3'd4;
  localparam logic [2:0] ST_WIN_APPLY = 3'd5;
  localparam logic [2:0] ST_FINISH    = 3'd6;

  logic [2:0] state;

  // Configuration registers
  logic [7:0] brake_on_angle;
  logic [7:0] brake_off_angle;
  logic [5:0] brake_speed_high;
  logic [5:0] brake_speed_low;
  logic [7:0] max_count_rise;
  logic [5:0] window_periods;
  logic [4:0] speed_floor;
  logic [4:0] speed_ceiling;

  // Block state
  logic        steer_phase;
  logic [7:0]  steer_angle;
  logic        brake_phase;
  logic [7:0]  brake_angle;
  logic [5:0]  period_count;
  logic [15:0] pulse_count;
  logic [15:0] last_count;
  logic [4:0]  speed_value;
  logic [15:0] journey_count;
  logic        debouncing;

  // Event in flight
  logic [1:0]  op_q;
  logic [7:0]  target_q;
  logic        need_q;
  logic        res_pin;
  logic [15:0] res_reload;
  logic        res_dstart;
  logic        slew_up;
  logic [15:0] rise;
  logic        rise_pos;
  logic [dspsg_pkg::RELOAD_W-1:0] reload_num;

  dspsg_pkg::div_req_t div_req;
  dspsg_pkg::div_rsp_t div_rsp;

  // Datapath around the shared divider
  logic                             in_xfer;
  logic                             out_free;
  logic                             load_out;
  logic [7:0]                       acc_angle;
  logic                             acc_high;
  logic [dspsg_pkg::RELOAD_W-1:0]   angle_ext;
  logic [dspsg_pkg::RELOAD_W-1:0]   angle_scaled;
  logic [dspsg_pkg::RELOAD_W-1:0]   reload_dividend;
  logic [dspsg_pkg::PROD_W-1:0]     reload_prod;
  logic [dspsg_pkg::RELOAD_Q_W-1:0] reload_quo;
  logic [7:0]                       slew_diff;
  logic [5:0]                       speed_gap;
  logic [6:0]                       gap_triple;
  logic [dspsg_pkg::DIVISOR_W-1:0]  slew_div;
  logic [5:0]                       period_inc;
  logic [15:0]                      reload_calc;
  logic [7:0]                       slew_step;
  logic [15:0]                      capped_count;
  logic                             cap_hit;
  logic [4:0]                       ceil_lim;
  logic [4:0]                       spd;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_out = (state == ST_FINISH) && out_free;

  // Reload dividend: angle*1023, plus 99 to round up in the high phase
  assign acc_angle       = (operation == dspsg_pkg::OP_BRAKE) ? brake_angle : steer_angle;
  assign acc_high        = (operation == dspsg_pkg::OP_BRAKE) ? !brake_phase : !steer_phase;
  assign angle_ext       = {10'b0, acc_angle};
  assign angle_scaled    = (angle_ext << 10) - angle_ext;
  assign reload_dividend = angle_scaled + (acc_high ? dspsg_pkg::ROUND_UP : '0);

  // Divide by 100: multiply by the reciprocal and keep the upper bits
  assign reload_prod = {{dspsg_pkg::RECIP_W{1'b0}}, reload_num} *
                       {{dspsg_pkg::RELOAD_W{1'b0}}, dspsg_pkg::RELOAD_RECIP};
  assign reload_quo  = reload_prod[dspsg_pkg::RECIP_SHIFT +: dspsg_pkg::RELOAD_Q_W];

  // Slew divisor: floor(3*(32 - speed)/2), between 1 and 48
  assign slew_diff  = (target_q > steer_angle) ? (target_q - steer_angle)
                                               : (steer_angle - target_q);
  assign speed_gap  = dspsg_pkg::SPEED_SPAN - {1'b0, speed_value};
  assign gap_triple = {1'b0, speed_gap} + {speed_gap, 1'b0};
  assign slew_div   = {1'b0, gap_triple[6:1]};

  assign period_inc  = period_count + 6'd1;
  assign reload_calc = res_pin ? (dspsg_pkg::HIGH_BASE - 16'(reload_quo))
                               : (dspsg_pkg::LOW_BASE + 16'(reload_quo));
  assign slew_step   = div_rsp.quotient[7:0] + dspsg_pkg::SLEW_BIAS;

  // Window: cap the count rise, then clamp ceiling first and floor last
  assign capped_count = last_count + {8'b0, max_count_rise};
  assign cap_hit      = rise_pos && (rise > {8'b0, max_count_rise});
  assign ceil_lim     = (last_count > {11'b0, speed_ceiling}) ? speed_ceiling : last_count[4:0];
  assign spd          = (ceil_lim < speed_floor) ? speed_floor : ceil_lim;

  dspsg_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      brake_on_angle   <= dspsg_pkg::RST_BRAKE_ON;
      brake_off_angle  <= dspsg_pkg::RST_BRAKE_OFF;
      brake_speed_high <= dspsg_pkg::RST_SPEED_HIGH;
      brake_speed_low  <= dspsg_pkg::RST_SPEED_LOW;
      max_count_rise   <= dspsg_pkg::RST_MAX_RISE;
      window_periods   <= dspsg_pkg::RST_WINDOW;
      speed_floor      <= dspsg_pkg::RST_FLOOR;
      speed_ceiling    <= dspsg_pkg::RST_CEILING;
    end else if (cfg_write) begin
      case (cfg_index)
        dspsg_pkg::REG_BRAKE_ON:   brake_on_angle   <= cfg_data;
        dspsg_pkg::REG_BRAKE_OFF:  brake_off_angle  <= cfg_data;
        dspsg_pkg::REG_SPEED_HIGH: brake_speed_high <= cfg_data[5:0];
        dspsg_pkg::REG_SPEED_LOW:  brake_speed_low  <= cfg_data[5:0];
        dspsg_pkg::REG_MAX_RISE:   max_count_rise   <= cfg_data;
        dspsg_pkg::REG_WINDOW:     window_periods   <= cfg_data[5:0];
        dspsg_pkg::REG_FLOOR:      speed_floor      <= cfg_data[4:0];
        dspsg_pkg::REG_CEILING:    speed_ceiling    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      steer_phase   <= 1'b0;
      steer_angle   <= dspsg_pkg::RST_ANGLE;
      brake_phase   <= 1'b0;
      brake_angle   <= dspsg_pkg::RST_ANGLE;
      period_count  <= '0;
      pulse_count   <= '0;
      last_count    <= '0;
      speed_value   <= dspsg_pkg::RST_SPEED;
      journey_count <= '0;
      debouncing    <= 1'b0;
      op_q          <= dspsg_pkg::OP_EDGE;
      target_q      <= '0;
      need_q        <= 1'b0;
      res_pin       <= 1'b0;
      res_reload    <= '0;
      res_dstart    <= 1'b0;
      slew_up       <= 1'b0;
      rise          <= '0;
      rise_pos      <= 1'b0;
      reload_num    <= '0;
      div_req       <= '0;
    end else begin
      div_req.start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            op_q       <= operation;
            target_q   <= target_angle;
            need_q     <= need_brake;
            res_pin    <= 1'b0;
            res_reload <= '0;
            res_dstart <= 1'b0;
            case (operation)
              dspsg_pkg::OP_STEER, dspsg_pkg::OP_BRAKE: begin
                // Toggle the phase; hold the reload numerator of the old angle
                res_pin <= acc_high;
                if (operation == dspsg_pkg::OP_BRAKE) begin
                  brake_phase <= !brake_phase;
                end else begin
                  steer_phase <= !steer_phase;
                end
                reload_num <= reload_dividend;
                state      <= ST_RELOAD;
              end
              dspsg_pkg::OP_EDGE: begin
                // Count the edge unless the debounce timer still runs
                if (!debouncing) begin
                  pulse_count   <= pulse_count + 16'd1;
                  journey_count <= journey_count + 16'd1;
                  debouncing    <= 1'b1;
                  res_dstart    <= 1'b1;
                end
                state <= ST_FINISH;
              end
              default: begin
                debouncing <= 1'b0;
                state      <= ST_FINISH;
              end
            endcase
          end
        end
        ST_RELOAD: begin
          res_reload <= reload_calc;
          if (!res_pin && (op_q == dspsg_pkg::OP_STEER) && (target_q != steer_angle)) begin
            slew_up          <= (target_q > steer_angle);
            div_req.start    <= 1'b1;
            div_req.dividend <= slew_diff;
            div_req.divisor  <= slew_div;
            state            <= ST_DIV_SLEW;
          end else if (!res_pin && (op_q == dspsg_pkg::OP_BRAKE)) begin
            if (period_inc >= window_periods) begin
              period_count <= '0;
              state        <= ST_WIN_RISE;
            end else begin
              period_count <= period_inc;
              state        <= ST_FINISH;
            end
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_DIV_SLEW: begin
          if (div_rsp.done) begin
            // Angle wraps in 8 bits on overshoot
            steer_angle <= slew_up ? (steer_angle + slew_step) : (steer_angle - slew_step);
            state       <= ST_FINISH;
          end
        end
        ST_WIN_RISE: begin
          rise     <= pulse_count - last_count;
          rise_pos <= (pulse_count > last_count);
          state    <= ST_WIN_CAP;
        end
        ST_WIN_CAP: begin
          last_count  <= cap_hit ? capped_count : pulse_count;
          pulse_count <= '0;
          state       <= ST_WIN_APPLY;
        end
        ST_WIN_APPLY: begin
          // last_count now holds the measured count of this window
          speed_value <= spd;
          if (need_q) begin
            if (last_count >= {10'b0, brake_speed_high}) begin
              brake_angle <= brake_on_angle;
            end else if (last_count <= {10'b0, brake_speed_low}) begin
              brake_angle <= brake_off_angle;
            end
          end else begin
            brake_angle <= brake_off_angle;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // Hold until the output register can take the result
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      servo_select   <= (op_q == dspsg_pkg::OP_STEER) ? dspsg_pkg::SEL_STEER :
                        (op_q == dspsg_pkg::OP_BRAKE) ? dspsg_pkg::SEL_BRAKE :
                                                        dspsg_pkg::SEL_NONE;
      pin_level      <= res_pin;
      reload_value   <= res_reload;
      debounce_start <= res_dstart;
      pulse_enable   <= !debouncing;
      measured_speed <= speed_value;
      distance_total <= journey_count;
    end
  end

  // The divider answers only while the sequencer waits for the slew step
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV_SLEW))
    else $error("divider done outside the slew state");

  // A finished result waits while the output register is still blocked
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_valid && out_stall) |=> (state == ST_FINISH))
    else $error("result left while output register was blocked");

  // Events without a servo carry no pin level and no reload
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && servo_select == dspsg_pkg::SEL_NONE) |-> (!pin_level && reload_value == '0))
    else $error("servo fields set on an event without a servo");

endmodule
